FILE: rtl/core/lfu_pkg.sv
`timescale 1ns / 1ps

package lfu_pkg;

  // Built frame table
  localparam int NUM_FRAMES  = 16;
  localparam int PAGE_BITS   = 16;
  localparam int FRAME_IDX_W = $clog2(NUM_FRAMES);
  localparam int FRAME_CNT_W = $clog2(NUM_FRAMES + 1);

  // Fixed field widths
  localparam int CFG_W       = 5;
  localparam int PAGE_W      = 16;
  localparam int SLOT_W      = 4;
  localparam int COUNT_W     = 16;
  localparam int TIME_W      = 32;
  localparam int FAULT_W     = 32;

  // Width holding both the register value and the built frame count
  localparam int MGD_W       = (FRAME_CNT_W > CFG_W) ? FRAME_CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = CFG_W'(4);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lfu_state_t;

endpackage

FILE: rtl/core/lfu_page_replacement_unit.sv
`timescale 1ns / 1ps

// Each item is scanned over the managed frames m (1..16), then committed in
//   ST_UPDATE; a hit found at frame j ends the scan early.
// A new item is taken only once the last one is committed (back in ST_IDLE);
//   the frame scan reads one table entry per cycle through a single comparator.
// Reset (rst_n low, synchronous): frames invalid, fill pointer, time and fault
//   count zero, frames_in_use = 4; no clearing pass, ready right after reset.
module lfu_page_replacement_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration: frames_in_use
  input  logic                       cfg_we,
  input  logic [lfu_pkg::CFG_W-1:0]  cfg_wdata,
  // reference items
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lfu_pkg::PAGE_W-1:0] in_page_number,
  // result items
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_hit,
  output logic [lfu_pkg::SLOT_W-1:0] out_frame_slot,
  output logic                       out_evicted_valid,
  output logic [lfu_pkg::PAGE_W-1:0] out_evicted_page,
  output logic [lfu_pkg::FAULT_W-1:0] out_fault_total
);

  localparam int N   = lfu_pkg::NUM_FRAMES;
  localparam int IW  = lfu_pkg::FRAME_IDX_W;
  localparam int CW  = lfu_pkg::FRAME_CNT_W;
  localparam int MW  = lfu_pkg::MGD_W;
  localparam int PB  = lfu_pkg::PAGE_BITS;
  localparam int UW  = lfu_pkg::COUNT_W;
  localparam int TW  = lfu_pkg::TIME_W;
  localparam int FW  = lfu_pkg::FAULT_W;

  // ---------------------------------------------------------------------------
  // Frame table. Only read at the scan index; written at the chosen slot.
  // ---------------------------------------------------------------------------
  logic [PB-1:0] frame_page_r [N];
  logic [UW-1:0] use_count_r  [N];
  logic [TW-1:0] last_time_r  [N];
  logic [N-1:0]  frame_valid_r;

  logic [CW-1:0] fill_ptr_r,   fill_ptr_nxt;
  logic [TW-1:0] ref_time_r,   ref_time_nxt;
  logic [FW-1:0] fault_cnt_r,  fault_cnt_nxt;
  logic [lfu_pkg::CFG_W-1:0] cfg_frames_r;

  lfu_pkg::lfu_state_t state_r, state_nxt;

  // per-item working registers
  logic [PB-1:0] page_r,      page_nxt;
  logic [IW-1:0] idx_r,       idx_nxt;
  logic          hit_r,       hit_nxt;
  logic [IW-1:0] hit_slot_r,  hit_slot_nxt;
  logic [IW-1:0] best_idx_r,  best_idx_nxt;
  logic [UW-1:0] best_cnt_r,  best_cnt_nxt;   // also holds the hit frame's count
  logic [TW-1:0] best_time_r, best_time_nxt;
  logic [PB-1:0] best_page_r, best_page_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic          out_hit_r,   out_hit_nxt;
  logic [lfu_pkg::SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic          out_ev_valid_r, out_ev_valid_nxt;
  logic [lfu_pkg::PAGE_W-1:0] out_ev_page_r, out_ev_page_nxt;
  logic [FW-1:0] out_fault_r, out_fault_nxt;

  // ---------------------------------------------------------------------------
  // Managed frame count: zero acts as one, above the built count clamps.
  // ---------------------------------------------------------------------------
  logic [MW-1:0] cfg_ext;
  logic [MW-1:0] managed;

  assign cfg_ext = MW'(cfg_frames_r);

  always_comb begin
    priority if (cfg_ext == '0) begin
      managed = MW'(1);
    end else if (cfg_ext > MW'(N)) begin
      managed = MW'(N);
    end else begin
      managed = cfg_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared scan unit: one frame per cycle, hit match plus LFU/oldest compare.
  // ---------------------------------------------------------------------------
  logic          scan_hit;
  logic          scan_last;
  logic          scan_better;
  logic [UW-1:0] scan_cnt;
  logic [TW-1:0] scan_time;

  assign scan_cnt  = use_count_r[idx_r];
  assign scan_time = last_time_r[idx_r];
  assign scan_hit  = frame_valid_r[idx_r] && (frame_page_r[idx_r] == page_r);
  assign scan_last = (MW'(idx_r) + MW'(1)) == managed;
  assign scan_better = (idx_r == '0) || (scan_cnt < best_cnt_r) ||
                       ((scan_cnt == best_cnt_r) && (scan_time < best_time_r));

  // ---------------------------------------------------------------------------
  // Commit of one reference
  // ---------------------------------------------------------------------------
  logic          fill_case;
  logic          ev_valid;
  logic [IW-1:0] slot;
  logic          out_free;
  logic          commit;

  assign fill_case = MW'(fill_ptr_r) < managed;
  assign ev_valid  = !hit_r && !fill_case;   // eviction is reported only on a miss with a full table
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (state_r == lfu_pkg::ST_UPDATE) && out_free;

  always_comb begin
    priority if (hit_r) begin
      slot = hit_slot_r;
    end else if (fill_case) begin
      slot = fill_ptr_r[IW-1:0];
    end else begin
      slot = best_idx_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt        = state_r;
    page_nxt         = page_r;
    idx_nxt          = idx_r;
    hit_nxt          = hit_r;
    hit_slot_nxt     = hit_slot_r;
    best_idx_nxt     = best_idx_r;
    best_cnt_nxt     = best_cnt_r;
    best_time_nxt    = best_time_r;
    best_page_nxt    = best_page_r;
    fill_ptr_nxt     = fill_ptr_r;
    ref_time_nxt     = ref_time_r;
    fault_cnt_nxt    = fault_cnt_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_hit_nxt      = out_hit_r;
    out_slot_nxt     = out_slot_r;
    out_ev_valid_nxt = out_ev_valid_r;
    out_ev_page_nxt  = out_ev_page_r;
    out_fault_nxt    = out_fault_r;
    in_stall         = 1'b1;

    unique case (state_r)
      lfu_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          page_nxt  = PB'(in_page_number);
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = lfu_pkg::ST_SCAN;
        end
      end

      lfu_pkg::ST_SCAN: begin
        if (scan_hit) begin
          hit_nxt      = 1'b1;
          hit_slot_nxt = idx_r;
          best_cnt_nxt = scan_cnt;
          state_nxt    = lfu_pkg::ST_UPDATE;
        end else begin
          if (scan_better) begin
            best_idx_nxt  = idx_r;
            best_cnt_nxt  = scan_cnt;
            best_time_nxt = scan_time;
            best_page_nxt = frame_page_r[idx_r];
          end
          if (scan_last) begin
            state_nxt = lfu_pkg::ST_UPDATE;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end

      lfu_pkg::ST_UPDATE: begin
        if (out_free) begin
          if (!hit_r) begin
            if (fill_case) begin
              fill_ptr_nxt = fill_ptr_r + CW'(1);
            end
            if (fault_cnt_r != '1) begin
              fault_cnt_nxt = fault_cnt_r + FW'(1);
            end
          end
          ref_time_nxt     = ref_time_r + TW'(1);
          out_valid_nxt    = 1'b1;
          out_hit_nxt      = hit_r;
          out_slot_nxt     = lfu_pkg::SLOT_W'(slot);
          out_ev_valid_nxt = ev_valid;
          out_ev_page_nxt  = ev_valid ? lfu_pkg::PAGE_W'(best_page_r) : '0;
          out_fault_nxt    = (!hit_r && (fault_cnt_r != '1)) ? fault_cnt_r + FW'(1)
                                                             : fault_cnt_r;
          state_nxt        = lfu_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= lfu_pkg::ST_IDLE;
      frame_valid_r <= '0;
      fill_ptr_r    <= '0;
      ref_time_r    <= '0;
      fault_cnt_r   <= '0;
      cfg_frames_r  <= lfu_pkg::FRAMES_IN_USE_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_ptr_r  <= fill_ptr_nxt;
      ref_time_r  <= ref_time_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_frames_r <= cfg_wdata;
      end
      if (commit && !hit_r) begin
        frame_valid_r[slot] <= 1'b1;
      end
    end
  end

  // Payload and table contents
  always_ff @(posedge clk) begin
    page_r         <= page_nxt;
    idx_r          <= idx_nxt;
    hit_r          <= hit_nxt;
    hit_slot_r     <= hit_slot_nxt;
    best_idx_r     <= best_idx_nxt;
    best_cnt_r     <= best_cnt_nxt;
    best_time_r    <= best_time_nxt;
    best_page_r    <= best_page_nxt;
    out_hit_r      <= out_hit_nxt;
    out_slot_r     <= out_slot_nxt;
    out_ev_valid_r <= out_ev_valid_nxt;
    out_ev_page_r  <= out_ev_page_nxt;
    out_fault_r    <= out_fault_nxt;
    if (commit) begin
      last_time_r[slot] <= ref_time_r;
      if (hit_r) begin
        if (best_cnt_r != '1) begin
          use_count_r[slot] <= best_cnt_r + UW'(1);
        end
      end else begin
        frame_page_r[slot] <= page_r;
        use_count_r[slot]  <= UW'(1);
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_slot    = out_slot_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_total   = out_fault_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_ev_valid_r && out_hit_r))
    else $error("eviction reported on a hit");

  a_fill_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_ptr_r <= CW'(N))
    else $error("fill pointer beyond frame table");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lfu_pkg::ST_SCAN) |-> (MW'(idx_r) < managed))
    else $error("scan index outside managed frames");

  a_fault_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (fault_cnt_r >= $past(fault_cnt_r)))
    else $error("fault count went down");

  a_slot_valid_after: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> frame_valid_r[$past(slot)])
    else $error("committed frame not marked valid");

endmodule

FILE: test/lfu_page_replacement_unit_tb.sv
`timescale 1ns / 1ps

module lfu_page_replacement_unit_tb;

  // one result item, field order as on the out_ ports
  typedef struct packed {
    logic                        hit;
    logic [lfu_pkg::SLOT_W-1:0]  slot;
    logic                        ev_valid;
    logic [lfu_pkg::PAGE_W-1:0]  ev_page;
    logic [lfu_pkg::FAULT_W-1:0] faults;
  } lfu_outcome_t;

  typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;

  // directed row: a config write (value low bits) or a page reference repeated reps times;
  // want is used instead of the predictor only where typed is set
  typedef struct packed {
    row_kind_t    kind;
    logic [15:0]  value;
    int unsigned  reps;
    logic         typed;
    lfu_outcome_t want;
  } stim_row_t;

  localparam int N_DIRECTED  = 26;
  localparam int N_PHASES    = 12;
  localparam int PHASE_ITEMS = 138;
  localparam int HOT_PAGES   = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int HIT_REPS    = 6;   // repeated hits so the two frames tie on count

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [lfu_pkg::CFG_W-1:0]    cfg_wdata;
  logic                         in_valid;
  logic                         in_stall;
  logic [lfu_pkg::PAGE_W-1:0]   in_page_number;
  logic                         out_valid;
  logic                         out_stall;
  logic                         out_hit;
  logic [lfu_pkg::SLOT_W-1:0]   out_frame_slot;
  logic                         out_evicted_valid;
  logic [lfu_pkg::PAGE_W-1:0]   out_evicted_page;
  logic [lfu_pkg::FAULT_W-1:0]  out_fault_total;

  lfu_page_replacement_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame_slot    (out_frame_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Frame table predictor: own copy of the table, clock and fault count.
  // ---------------------------------------------------------------------------
  logic [lfu_pkg::PAGE_W-1:0]  fr_page  [lfu_pkg::NUM_FRAMES];
  logic                        fr_valid [lfu_pkg::NUM_FRAMES];
  logic [lfu_pkg::COUNT_W-1:0] fr_uses  [lfu_pkg::NUM_FRAMES];
  logic [lfu_pkg::TIME_W-1:0]  fr_stamp [lfu_pkg::NUM_FRAMES];
  int unsigned                 next_fill;
  logic [lfu_pkg::TIME_W-1:0]  ref_clock;
  logic [lfu_pkg::FAULT_W-1:0] faults_seen;
  logic [lfu_pkg::CFG_W-1:0]   frames_reg;

  lfu_outcome_t awaited_outcomes [$];
  int unsigned  mismatch_count;

  // shared between driver and receiver
  bit jitter_on;          // random gaps and stalls allowed
  bit backpressure_req;   // receiver should hold off for a long stretch

  function automatic void clear_frame_table();
    for (int k = 0; k < lfu_pkg::NUM_FRAMES; k++) begin
      fr_page[k]  = '0;
      fr_valid[k] = 1'b0;
      fr_uses[k]  = '0;
      fr_stamp[k] = '0;
    end
    next_fill   = 0;
    ref_clock   = '0;
    faults_seen = '0;
    frames_reg  = lfu_pkg::FRAMES_IN_USE_RST;
  endfunction

  // one reference against the table; updates state and returns the outcome
  function automatic lfu_outcome_t lfu_lookup(input logic [lfu_pkg::PAGE_W-1:0] page);
    lfu_outcome_t r;
    int unsigned  managed;
    int unsigned  slot;
    int unsigned  victim;
    bit           found;
    r       = '0;
    found   = 1'b0;
    slot    = 0;
    managed = 32'(frames_reg);
    if (managed < 1) managed = 1;
    if (managed > lfu_pkg::NUM_FRAMES) managed = lfu_pkg::NUM_FRAMES;
    // lowest matching index wins; frames above the managed count are invisible
    for (int unsigned j = 0; j < managed; j++) begin
      if (!found && fr_valid[j] && fr_page[j] == page) begin
        found = 1'b1;
        slot  = j;
      end
    end
    if (found) begin
      if (fr_uses[slot] != {lfu_pkg::COUNT_W{1'b1}})
        fr_uses[slot] = fr_uses[slot] + lfu_pkg::COUNT_W'(1);
      fr_stamp[slot] = ref_clock;
    end else begin
      if (next_fill < managed) begin
        slot      = next_fill;
        next_fill = next_fill + 1;
      end else begin
        // fewest uses, then oldest stamp, then lowest index
        victim = 0;
        for (int unsigned j = 1; j < managed; j++) begin
          if (fr_uses[j] < fr_uses[victim] ||
              (fr_uses[j] == fr_uses[victim] && fr_stamp[j] < fr_stamp[victim]))
            victim = j;
        end
        slot = victim;
      end
      if (fr_valid[slot]) begin
        r.ev_valid = 1'b1;
        r.ev_page  = fr_page[slot];
      end
      fr_page[slot]  = page;
      fr_valid[slot] = 1'b1;
      fr_uses[slot]  = lfu_pkg::COUNT_W'(1);
      fr_stamp[slot] = ref_clock;
      if (faults_seen != {lfu_pkg::FAULT_W{1'b1}})
        faults_seen = faults_seen + lfu_pkg::FAULT_W'(1);
    end
    ref_clock = ref_clock + lfu_pkg::TIME_W'(1);
    r.hit     = found;
    r.slot    = lfu_pkg::SLOT_W'(slot);
    r.faults  = faults_seen;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Right after reset four frames are managed, so the first
  // rows can be read off by hand; the rest go through the predictor.
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_REF, 16'h0000, 1, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}},   // cold fill
    '{ROW_REF, 16'hFFFF, 1, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 32'd2}},
    '{ROW_REF, 16'h0000, 1, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd2}},   // hit
    '{ROW_REF, 16'hAAAA, 1, 1'b1, '{1'b0, 4'd2, 1'b0, 16'h0000, 32'd3}},
    '{ROW_REF, 16'h5555, 1, 1'b1, '{1'b0, 4'd3, 1'b0, 16'h0000, 32'd4}},
    // table full: frames 1..3 tie at one use, frame 1 is oldest
    '{ROW_REF, 16'h1234, 1, 1'b1, '{1'b0, 4'd1, 1'b1, 16'hFFFF, 32'd5}},
    '{ROW_CFG, 16'd0,    0, 1'b0, '0},                                     // zero acts as one
    // only frame 0 visible: its page 0 goes even though 5555 sits in frame 3
    '{ROW_REF, 16'h5555, 1, 1'b1, '{1'b0, 4'd0, 1'b1, 16'h0000, 32'd6}},
    '{ROW_REF, 16'h5555, 1, 1'b0, '0},
    '{ROW_CFG, 16'd31,   0, 1'b0, '0},                                     // above range: all
    '{ROW_REF, 16'h0F0F, 1, 1'b0, '0},                                     // fill resumes
    '{ROW_REF, 16'hF0F0, 1, 1'b0, '0},
    '{ROW_CFG, 16'd2,    0, 1'b0, '0},                                     // shrink
    '{ROW_REF, 16'h1234, 1, 1'b0, '0},
    '{ROW_REF, 16'h0F0F, 1, 1'b0, '0},                                     // upper copy hidden
    '{ROW_CFG, 16'd16,   0, 1'b0, '0},
    '{ROW_REF, 16'h0F0F, 1, 1'b0, '0},                                     // duplicate pages
    '{ROW_CFG, 16'd17,   0, 1'b0, '0},
    '{ROW_REF, 16'h8001, 1, 1'b0, '0},
    '{ROW_CFG, 16'd2,    0, 1'b0, '0},
    // both visible frames driven to the same count, then the stamp decides
    '{ROW_REF, 16'h0100, HIT_REPS, 1'b0, '0},
    '{ROW_REF, 16'h0200, HIT_REPS, 1'b0, '0},
    '{ROW_REF, 16'h0300, 1, 1'b0, '0},
    '{ROW_REF, 16'h0100, 1, 1'b0, '0},
    '{ROW_CFG, 16'd1,    0, 1'b0, '0},
    '{ROW_REF, 16'h0100, 1, 1'b0, '0}
  };

  task automatic flag_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // offer one page until taken, then queue what it should produce
  task automatic send_reference(input logic [lfu_pkg::PAGE_W-1:0] page, input logic typed,
                                input lfu_outcome_t want);
    lfu_outcome_t predicted;
    while (jitter_on && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_page_number <= page;
    do @(posedge clk); while (in_stall);
    predicted = lfu_lookup(page);
    awaited_outcomes.push_back(typed ? want : predicted);
  endtask

  // register write only once the block has drained
  task automatic set_frames_in_use(input logic [lfu_pkg::CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    frames_reg  = value;
  endtask

  task automatic check_outcome();
    lfu_outcome_t want;
    if (awaited_outcomes.size() == 0) begin
      flag_mismatch($sformatf("result with nothing pending (slot %0d, faults %0d)",
                              out_frame_slot, out_fault_total));
      return;
    end
    want = awaited_outcomes.pop_front();
    if (out_hit !== want.hit)
      flag_mismatch($sformatf("hit %b, want %b", out_hit, want.hit));
    if (out_frame_slot !== want.slot)
      flag_mismatch($sformatf("frame_slot %0d, want %0d", out_frame_slot, want.slot));
    if (out_evicted_valid !== want.ev_valid)
      flag_mismatch($sformatf("evicted_valid %b, want %b", out_evicted_valid, want.ev_valid));
    if (out_evicted_page !== want.ev_page)
      flag_mismatch($sformatf("evicted_page %h, want %h", out_evicted_page, want.ev_page));
    if (out_fault_total !== want.faults)
      flag_mismatch($sformatf("fault_total %0d, want %0d", out_fault_total, want.faults));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: samples at the edge, then picks the stall for the next cycle.
  // A pressure request turns into a long hold counted here.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_outcome();
      if (backpressure_req) begin
        hold_left        = HOLD_CYCLES;
        backpressure_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= jitter_on && ($urandom_range(0, 99) < 6);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: reset, directed table, then random phases with a setting each.
  // ---------------------------------------------------------------------------
  initial begin
    logic [lfu_pkg::PAGE_W-1:0] hot_pages [HOT_PAGES];
    logic [lfu_pkg::CFG_W-1:0]  phase_cfg;
    logic [lfu_pkg::PAGE_W-1:0] page;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_valid         <= 1'b0;
    in_page_number   <= '0;
    jitter_on         = 1'b1;
    backpressure_req  = 1'b0;
    mismatch_count    = 0;
    clear_frame_table();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        set_frames_in_use(directed_rows[i].value[lfu_pkg::CFG_W-1:0]);
      else
        repeat (directed_rows[i].reps)
          send_reference(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // extremes and a middle value first, then random settings (0 and above 16 included)
      case (ph)
        0:       phase_cfg = lfu_pkg::CFG_W'(16);
        1:       phase_cfg = lfu_pkg::CFG_W'(1);
        2:       phase_cfg = lfu_pkg::CFG_W'(31);
        3:       phase_cfg = lfu_pkg::CFG_W'(0);
        4:       phase_cfg = lfu_pkg::CFG_W'(8);
        default: phase_cfg = lfu_pkg::CFG_W'($urandom_range(0, 31));
      endcase
      set_frames_in_use(phase_cfg);
      jitter_on = (ph != 2);   // one stretch runs flat out
      // small working set per phase so hits, ties and evictions are common
      foreach (hot_pages[k]) hot_pages[k] = lfu_pkg::PAGE_W'($urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == 10) backpressure_req = 1'b1;
        if ($urandom_range(0, 99) < 75)
          page = hot_pages[$urandom_range(0, $urandom_range(0, HOT_PAGES - 1))];
        else
          page = lfu_pkg::PAGE_W'($urandom);
        send_reference(page, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);   // catch any stray result
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
